// ----- rtl/core/klin_pkg.sv -----
// shared types, constants and helpers for the keyframe linear interpolator
`default_nettype none
package klin_pkg;
	localparam int NUM_CH   = 11;
	localparam int MAX_KF   = 256;
	localparam int KF_DEPTH = MAX_KF * NUM_CH;
	localparam int KF_AW    = $clog2(KF_DEPTH);
	localparam int CH_W     = 4;
	localparam int CNT_W    = 9;
	localparam int SEG_W    = 8;
	localparam int STEPS_W  = 10;
	localparam int NUDGE_W  = 16;
	localparam int DIV_STEPS = 33;
	localparam int DIV_CW   = $clog2(DIV_STEPS + 1);

	// configuration register indexes
	localparam logic REG_STEPS = 1'b0;
	localparam logic REG_NUDGE = 1'b1;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_CAPTURE = 2'd1,
		OP_PLAY    = 2'd2,
		OP_NUDGE   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]      op;
		logic [CH_W-1:0] channel;
		logic            direction;
	} klin_in_t;

	typedef struct packed {
		logic [CH_W-1:0]    channel_res;
		logic signed [31:0] value;
		logic               last;
		logic               playing;
		logic [CNT_W-1:0]   keyframe_count;
		logic [SEG_W-1:0]   segment;
	} klin_out_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quot;
	} div_status_t;

	// clamp a 34-bit signed value into the signed 32-bit range
	function automatic logic signed [31:0] clamp34(input logic signed [33:0] v);
		logic signed [33:0] hi;
		logic signed [33:0] lo;
		hi = 34'sh0_7FFF_FFFF;
		lo = -34'sh0_8000_0000;
		if (v > hi) return 32'sh7FFF_FFFF;
		if (v < lo) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// saturating signed add
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
	                                                input logic signed [31:0] b);
		logic signed [33:0] s;
		s = 34'(a) + 34'(b);
		return clamp34(s);
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/klin_div.sv -----
// iterative restoring divider: signed 33-bit dividend by unsigned 10-bit divisor
`default_nettype none
module klin_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic signed [32:0]            dividend,
	input  wire logic [klin_pkg::STEPS_W-1:0]  divisor,
	output klin_pkg::div_status_t              status
);
	logic [32:0]                     mag_q;
	logic [klin_pkg::STEPS_W:0]      rem_q;
	logic                            neg_q;
	logic                            busy_q;
	logic                            done_q;
	logic [klin_pkg::DIV_CW-1:0]     cnt_q;
	logic [klin_pkg::STEPS_W+1:0]    rem_sh;
	logic [klin_pkg::STEPS_W+1:0]    rem_sub;
	logic                            qbit;
	logic signed [33:0]              q_signed;

	// one quotient bit per cycle
	always_comb begin
		rem_sh  = {rem_q, mag_q[32]};
		rem_sub = rem_sh - {2'b00, divisor};
		qbit    = (rem_sh >= {2'b00, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == klin_pkg::DIV_CW'(klin_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[32];
			mag_q <= dividend[32] ? 33'(-dividend) : dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? rem_sub[klin_pkg::STEPS_W:0] : rem_sh[klin_pkg::STEPS_W:0];
			mag_q <= {mag_q[31:0], qbit};
		end
	end

	// sign restore and clamp
	always_comb begin
		q_signed = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
		status.done = done_q;
		status.quot = klin_pkg::clamp34(q_signed);
	end
endmodule
`default_nettype wire

// ----- rtl/core/klin_kf_mem.sv -----
// keyframe store: one write port, one registered read port
`default_nettype none
module klin_kf_mem (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [klin_pkg::KF_AW-1:0]  waddr,
	input  wire logic [31:0]                 wdata,
	input  wire logic [klin_pkg::KF_AW-1:0]  raddr,
	output logic [31:0]                      rdata
);
	logic [31:0] mem_q [klin_pkg::KF_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/core/keyframe_linear_interpolator_top.sv -----
// top level: op sequencer, pose and increment registers, keyframe store, divider
// Sequence: tick, nudge and stopping toggle go straight to the 11 results; capture
// first writes each channel's pose into the store; segment start first reads keyframes
// a and b from the store and runs the bit-serial divider, channel by channel.
// Throughput: one op at a time; its 11 results leave one per cycle as out_ready allows.
// Reset: asynchronous active low; pose, increments, counters and playback cleared,
// registers back to 190 and 655; the keyframe store is not cleared.
`default_nettype none
module keyframe_linear_interpolator_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire klin_pkg::klin_in_t           in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output klin_pkg::klin_out_t               out_data,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [15:0]                  cfg_data
);
	typedef enum logic [2:0] {
		S_IDLE, S_CAP, S_RA, S_RB, S_DS, S_DW, S_EMIT
	} state_t;

	state_t                           state_q;
	logic [klin_pkg::STEPS_W-1:0]     steps_q;
	logic [klin_pkg::NUDGE_W-1:0]     nudge_q;
	logic signed [31:0]               pose_q [klin_pkg::NUM_CH];
	logic signed [31:0]               inc_q  [klin_pkg::NUM_CH];
	logic [klin_pkg::CNT_W-1:0]       count_q;
	logic [klin_pkg::SEG_W-1:0]       seg_q;
	logic [klin_pkg::STEPS_W-1:0]     sc_q;
	logic                             playing_q;
	logic                             load_q;
	logic [klin_pkg::CH_W-1:0]        k_q;
	logic [31:0]                      ka_q;

	logic                             accept;
	logic [klin_pkg::STEPS_W-1:0]     eff;
	logic [klin_pkg::KF_AW-1:0]       seg_base;
	logic [klin_pkg::KF_AW-1:0]       raddr;
	logic [klin_pkg::KF_AW-1:0]       waddr;
	logic                             mem_we;
	logic [31:0]                      rdata;
	logic signed [32:0]               diff;
	logic                             div_start;
	klin_pkg::div_status_t            div_st;
	logic                             k_last;
	logic signed [33:0]               nudge_d;

	// handshake and helpers
	always_comb begin
		in_ready = (state_q == S_IDLE);
		accept   = in_valid && in_ready;
		eff      = (steps_q == '0) ? klin_pkg::STEPS_W'(1) : steps_q;
		k_last   = (k_q == klin_pkg::CH_W'(klin_pkg::NUM_CH - 1));
		seg_base = klin_pkg::KF_AW'(seg_q) * klin_pkg::KF_AW'(klin_pkg::NUM_CH);
		raddr    = seg_base + klin_pkg::KF_AW'(k_q)
		         + ((state_q == S_RB) ? klin_pkg::KF_AW'(klin_pkg::NUM_CH) : '0);
		waddr    = klin_pkg::KF_AW'(count_q) * klin_pkg::KF_AW'(klin_pkg::NUM_CH)
		         + klin_pkg::KF_AW'(k_q);
		mem_we   = (state_q == S_CAP);
		diff     = $signed({rdata[31], rdata}) - $signed({ka_q[31], ka_q});
		div_start = (state_q == S_DS);
		nudge_d  = in_data.direction ? -34'(nudge_q) : 34'(nudge_q);
	end

	klin_kf_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (pose_q[k_q]),
		.raddr (raddr),
		.rdata (rdata)
	);

	klin_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff),
		.divisor  (eff),
		.status   (div_st)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= klin_pkg::STEPS_W'(190);
			nudge_q <= klin_pkg::NUDGE_W'(655);
		end else if (cfg_we) begin
			case (cfg_index)
				klin_pkg::REG_STEPS: steps_q <= cfg_data[klin_pkg::STEPS_W-1:0];
				klin_pkg::REG_NUDGE: nudge_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			seg_q     <= '0;
			sc_q      <= '0;
			playing_q <= 1'b0;
			load_q    <= 1'b0;
			k_q       <= '0;
			for (int i = 0; i < klin_pkg::NUM_CH; i++) begin
				pose_q[i] <= '0;
				inc_q[i]  <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						k_q     <= '0;
						state_q <= S_EMIT;
						case (klin_pkg::op_t'(in_data.op))
							klin_pkg::OP_TICK: begin
								if (playing_q) begin
									if (sc_q >= eff) begin
										if ({2'b00, seg_q} + 10'd3 > {1'b0, count_q}) begin
											seg_q     <= '0;
											playing_q <= 1'b0;
										end else begin
											seg_q   <= seg_q + 1'b1;
											sc_q    <= '0;
											load_q  <= 1'b0;
											state_q <= S_RA;
										end
									end else begin
										for (int i = 0; i < klin_pkg::NUM_CH; i++) begin
											pose_q[i] <= klin_pkg::sat_add(pose_q[i], inc_q[i]);
										end
										sc_q <= sc_q + 1'b1;
									end
								end
							end
							klin_pkg::OP_CAPTURE: begin
								if (count_q < klin_pkg::CNT_W'(klin_pkg::MAX_KF)) begin
									state_q <= S_CAP;
								end
							end
							klin_pkg::OP_PLAY: begin
								if (!playing_q && count_q > klin_pkg::CNT_W'(1)) begin
									seg_q     <= '0;
									sc_q      <= '0;
									load_q    <= 1'b1;
									playing_q <= 1'b1;
									state_q   <= S_RA;
								end else begin
									playing_q <= 1'b0;
								end
							end
							klin_pkg::OP_NUDGE: begin
								for (int i = 0; i < klin_pkg::NUM_CH; i++) begin
									if (in_data.channel == klin_pkg::CH_W'(i)) begin
										pose_q[i] <= klin_pkg::clamp34(34'(pose_q[i]) + nudge_d);
									end
								end
							end
							default: ;
						endcase
					end
				end
				// copy pose into the next keyframe, one channel a cycle
				S_CAP: begin
					if (k_last) begin
						k_q     <= '0;
						count_q <= count_q + 1'b1;
						state_q <= S_EMIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				// read keyframe a, then b, then divide the difference
				S_RA: state_q <= S_RB;
				S_RB: begin
					ka_q    <= rdata;
					state_q <= S_DS;
				end
				S_DS: begin
					if (load_q) begin
						pose_q[k_q] <= ka_q;
					end
					state_q <= S_DW;
				end
				S_DW: begin
					if (div_st.done) begin
						inc_q[k_q] <= div_st.quot;
						if (k_last) begin
							k_q     <= '0;
							state_q <= S_EMIT;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_RA;
						end
					end
				end
				// report every channel
				S_EMIT: begin
					if (out_ready) begin
						if (k_last) begin
							k_q     <= '0;
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result transaction payload
	always_comb begin
		out_valid               = (state_q == S_EMIT);
		out_data.channel_res    = k_q;
		out_data.value          = pose_q[k_q];
		out_data.last           = k_last;
		out_data.playing        = playing_q;
		out_data.keyframe_count = count_q;
		out_data.segment        = seg_q;
	end
endmodule
`default_nettype wire

// ----- dv/klin_checker.sv -----
// checker for the keyframe linear interpolator: pose predictor and result comparison
module klin_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  klin_pkg::klin_in_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  klin_pkg::klin_out_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	output int                  errors,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import klin_pkg::*;

	// predicted pose, store and playback state
	logic signed [31:0]  pose_q [NUM_CH];
	logic signed [31:0]  incr_q [NUM_CH];
	logic signed [31:0]  kf_mem [MAX_KF][NUM_CH];
	int unsigned         kf_count;
	int unsigned         seg_idx;
	int unsigned         tick_cnt;
	bit                  run_q;
	logic [STEPS_W-1:0]  steps_reg;
	logic [NUDGE_W-1:0]  nudge_reg;
	klin_out_t           pose_reports [$];

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic longint seg_ticks();
		return (steps_reg == 0) ? 1 : longint'(steps_reg);
	endfunction

	// per-channel slope toward the next keyframe
	task automatic load_slopes();
		longint diff;
		if (seg_idx + 1 >= kf_count || seg_idx + 1 >= MAX_KF) return;
		for (int k = 0; k < NUM_CH; k++) begin
			diff = longint'(kf_mem[seg_idx+1][k]) - longint'(kf_mem[seg_idx][k]);
			incr_q[k] = sat32(diff / seg_ticks());
		end
	endtask

	// apply one op and queue the eleven channel reports
	task automatic apply_op(input klin_in_t t);
		klin_out_t r;
		case (op_t'(t.op))
			OP_TICK: begin
				if (run_q) begin
					if (longint'(tick_cnt) >= seg_ticks()) begin
						seg_idx++;
						if (seg_idx + 2 > kf_count) begin
							seg_idx = 0;
							run_q = 0;
						end else begin
							tick_cnt = 0;
							load_slopes();
						end
					end else begin
						for (int k = 0; k < NUM_CH; k++)
							pose_q[k] = sat32(longint'(pose_q[k]) + longint'(incr_q[k]));
						tick_cnt = (tick_cnt + 1) & 10'h3FF;
					end
				end
			end
			OP_CAPTURE: begin
				if (kf_count < MAX_KF) begin
					for (int k = 0; k < NUM_CH; k++) kf_mem[kf_count][k] = pose_q[k];
					kf_count++;
				end
			end
			OP_PLAY: begin
				if (!run_q && kf_count > 1) begin
					for (int k = 0; k < NUM_CH; k++) pose_q[k] = kf_mem[0][k];
					seg_idx = 0;
					tick_cnt = 0;
					load_slopes();
					run_q = 1;
				end else begin
					run_q = 0;
				end
			end
			default: begin
				if (t.channel < NUM_CH)
					pose_q[t.channel] = sat32(longint'(pose_q[t.channel]) +
						(t.direction ? -longint'(nudge_reg) : longint'(nudge_reg)));
			end
		endcase
		for (int k = 0; k < NUM_CH; k++) begin
			r.channel_res    = CH_W'(k);
			r.value          = pose_q[k];
			r.last           = (k == NUM_CH - 1);
			r.playing        = run_q;
			r.keyframe_count = CNT_W'(kf_count);
			r.segment        = SEG_W'(seg_idx);
			pose_reports = {pose_reports, r};
		end
	endtask

	// compare output transactions, then track config and input transactions
	always @(posedge clk or negedge arst_n) begin
		klin_out_t want;
		if (!arst_n) begin
			for (int k = 0; k < NUM_CH; k++) begin
				pose_q[k] = '0;
				incr_q[k] = '0;
			end
			kf_count  = 0;
			seg_idx   = 0;
			tick_cnt  = 0;
			run_q     = 0;
			steps_reg = 10'd190;
			nudge_reg = 16'd655;
			errors    = 0;
			pose_reports.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (pose_reports.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %p", $time, out_data);
				end else begin
					want = pose_reports.pop_front();
					if (want.channel_res !== out_data.channel_res ||
					    want.value !== out_data.value || want.last !== out_data.last ||
					    want.playing !== out_data.playing ||
					    want.keyframe_count !== out_data.keyframe_count ||
					    want.segment !== out_data.segment) begin
						errors++;
						$display("%0t: mismatch expected %p actual %p", $time, want, out_data);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_STEPS) steps_reg = cfg_data[STEPS_W-1:0];
				else nudge_reg = cfg_data;
			end
			if (in_valid && in_ready) apply_op(in_data);
		end
		pending = pose_reports.size();
	end
endmodule

// ----- dv/tb_keyframe_linear_interpolator_top.sv -----
// testbench top for the keyframe linear interpolator: stimulus, idling and verdict
module tb_keyframe_linear_interpolator_top;
	timeunit 1ns;
	timeprecision 1ps;
	import klin_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	klin_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	klin_out_t   out_data;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_STEPS;
	logic [15:0] cfg_data = '0;
	int          errors;
	int          pending;
	int          tx_idle = 29;
	int          rx_idle = 69;
	int          hold_off = 0;
	int          quiet_cycles = 0;

	keyframe_linear_interpolator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	klin_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// offer one op, return at the falling edge after its transaction
	task automatic send_op(input op_t op, input logic [3:0] ch, input logic dir);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{op: op, channel: ch, direction: dir};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// drain the block, then write one register
	task automatic write_reg(input logic idx, input logic [15:0] val);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed keyframe work with random content
	task automatic random_ops(input int n);
		int r;
		op_t op;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 40) op = OP_TICK;
			else if (r < 55) op = OP_CAPTURE;
			else if (r < 68) op = OP_PLAY;
			else op = OP_NUDGE;
			send_op(op, 4'($urandom_range(15)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle tick, too few keyframes, nudge edges, bad channels
		send_op(OP_TICK, 4'd0, 1'b0);
		send_op(OP_PLAY, 4'd0, 1'b0);
		send_op(OP_NUDGE, 4'd0, 1'b0);
		send_op(OP_NUDGE, 4'd10, 1'b1);
		send_op(OP_NUDGE, 4'd11, 1'b0);
		send_op(OP_NUDGE, 4'd15, 1'b1);
		send_op(OP_CAPTURE, 4'd0, 1'b0);
		send_op(OP_PLAY, 4'd0, 1'b0);
		send_op(OP_NUDGE, 4'd3, 1'b0);
		send_op(OP_NUDGE, 4'd8, 1'b1);
		send_op(OP_CAPTURE, 4'd0, 1'b0);
		write_reg(REG_STEPS, 16'd3);
		write_reg(REG_NUDGE, 16'd65535);
		// playback through the only segment until it ends
		send_op(OP_PLAY, 4'd0, 1'b0);
		repeat (5) send_op(OP_TICK, 4'd0, 1'b0);
		send_op(OP_TICK, 4'd0, 1'b0);
		// start, nudge while playing, then stop mid-segment
		send_op(OP_PLAY, 4'd0, 1'b0);
		send_op(OP_TICK, 4'd0, 1'b0);
		send_op(OP_NUDGE, 4'd7, 1'b0);
		send_op(OP_PLAY, 4'd0, 1'b0);
		send_op(OP_TICK, 4'd0, 1'b0);

		// random with zero step count and zero nudge
		write_reg(REG_STEPS, 16'd0);
		write_reg(REG_NUDGE, 16'd0);
		random_ops(35);

		tx_idle = 69;
		rx_idle = 29;
		write_reg(REG_STEPS, 16'd1023);
		write_reg(REG_NUDGE, 16'($urandom_range(65535)));
		random_ops(15);
		write_reg(REG_STEPS, 16'($urandom_range(1, 4)));
		random_ops(20);

		// no idling; long receiver hold-off while ops keep coming
		tx_idle = 0;
		rx_idle = 0;
		write_reg(REG_STEPS, 16'd2);
		hold_off = 300;
		random_ops(15);
		// capture-heavy burst
		for (int i = 0; i < 12; i++) begin
			send_op(i % 3 == 0 ? OP_NUDGE : OP_CAPTURE,
				4'($urandom_range(10)), 1'($urandom_range(1)));
		end
		write_reg(REG_STEPS, 16'd1);
		write_reg(REG_NUDGE, 16'd1);
		random_ops(15);

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/core/klin_pkg.sv
rtl/core/klin_div.sv
rtl/core/klin_kf_mem.sv
rtl/core/keyframe_linear_interpolator_top.sv
dv/klin_checker.sv
dv/tb_keyframe_linear_interpolator_top.sv
